// ----- design/rgbp_pkg.sv -----
package rgbp_pkg;

    // Fixed field widths
    localparam int CH_W    = 8;    // one colour or level channel
    localparam int SIZE_W  = 7;    // ring size register
    localparam int WGT_W   = 11;   // blur weight, unsigned Q1.10
    localparam int RING_W  = 2;    // ring number
    localparam int POS_W   = 6;    // position within a ring
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;
    localparam int NUM_CH  = 4;    // red, green, blue, level
    localparam int MAX_RINGS = 4;

    // Blur arithmetic widths
    localparam int PS_W   = WGT_W + CH_W;        // weight * pixel
    localparam int PN_W   = WGT_W + CH_W + 1;    // weight * (left + right)
    localparam int SUM_W  = 22;                  // blur sum plus rounding
    localparam int FRAC_W = 10;                  // Q1.10 fraction bits
    localparam int RND_W  = SUM_W - FRAC_W;
    localparam int SCL_W  = 2 * CH_W;            // channel * level

    // Channel lanes inside a stored word
    localparam int CH_RED   = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_BLUE  = 2;
    localparam int CH_LEVEL = 3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RING0_SIZE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RING1_SIZE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RING2_SIZE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RING3_SIZE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SELF_WGT    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_NEIGH_WGT   = 3'd5;

    // Reset values of the configuration registers
    localparam logic [SIZE_W-1:0] RST_RING0_SIZE = 7'd36;
    localparam logic [SIZE_W-1:0] RST_RING1_SIZE = 7'd30;
    localparam logic [SIZE_W-1:0] RST_RING2_SIZE = 7'd24;
    localparam logic [SIZE_W-1:0] RST_RING3_SIZE = 7'd18;
    localparam logic [WGT_W-1:0]  RST_SELF_WGT   = 11'd717;
    localparam logic [WGT_W-1:0]  RST_NEIGH_WGT  = 11'd154;

    localparam logic [CH_W-1:0] CH_MAX = 8'd255;

    typedef logic [NUM_CH-1:0][CH_W-1:0] word_t;

    typedef struct packed {
        logic [CH_W-1:0] pix_red;
        logic [CH_W-1:0] pix_green;
        logic [CH_W-1:0] pix_blue;
        logic [CH_W-1:0] pix_level;
        logic            frame_start;
    } pix_t;

    typedef struct packed {
        logic [RING_W-1:0] out_ring;
        logic [POS_W-1:0]  out_position;
        logic [CH_W-1:0]   out_red;
        logic [CH_W-1:0]   out_green;
        logic [CH_W-1:0]   out_blue;
        logic              ring_done;
        logic              frame_done;
    } res_t;

    // Travels with each read down the pipeline
    typedef struct packed {
        logic              emit;
        logic [RING_W-1:0] ring;
        logic [POS_W-1:0]  pos;
        logic              ring_done;
        logic              frame_done;
    } tag_t;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
        tag_t tag;
    } cmd_t;

    typedef enum logic {
        ST_FILL,
        ST_EMIT
    } state_t;

endpackage

// ----- design/rgbp_ctrl.sv -----
module rgbp_ctrl #(
    parameter int MAX_RING_LEDS = 64,
    parameter int RING_COUNT    = 4
) (
    input  logic                                             clk,
    input  logic                                             rst_n,
    input  logic [rgbp_pkg::MAX_RINGS-1:0][rgbp_pkg::SIZE_W-1:0] ring_size,
    input  logic                                             in_valid,
    input  logic                                             frame_start,
    output logic                                             in_ready,
    input  logic                                             adv,
    output rgbp_pkg::cmd_t                                   cmd,
    output logic [$clog2(MAX_RING_LEDS)-1:0]                 wr_addr,
    output logic [$clog2(MAX_RING_LEDS)-1:0]                 rd_addr
);

    localparam int IDX_W  = $clog2(MAX_RING_LEDS);
    localparam int SIZE_W = rgbp_pkg::SIZE_W;
    localparam int RING_W = rgbp_pkg::RING_W;
    localparam int RINGS_USED = (RING_COUNT < 1) ? 1 :
                                (RING_COUNT > rgbp_pkg::MAX_RINGS) ? rgbp_pkg::MAX_RINGS :
                                RING_COUNT;
    localparam logic [RING_W:0]   RINGS_USED_V = (RING_W+1)'(RINGS_USED);
    localparam logic [SIZE_W-1:0] MAX_SIZE     = SIZE_W'(MAX_RING_LEDS);
    localparam logic [SIZE_W-1:0] ONE_SIZE     = SIZE_W'(1);
    localparam logic [SIZE_W-1:0] TWO_SIZE     = SIZE_W'(2);

    rgbp_pkg::state_t state_reg, state_next;

    logic [RING_W-1:0] ring_reg, ring_next;
    logic [IDX_W-1:0]  fill_reg, fill_next;
    logic [SIZE_W-1:0] emit_size_reg, emit_size_next;
    logic [RING_W-1:0] emit_ring_reg, emit_ring_next;
    logic              emit_last_reg, emit_last_next;
    logic [SIZE_W-1:0] rd_cnt_reg, rd_cnt_next;
    logic [IDX_W-1:0]  rd_addr_reg, rd_addr_next;

    logic              accept;
    logic [RING_W-1:0] eff_ring;
    logic [IDX_W-1:0]  eff_fill;
    logic [SIZE_W-1:0] size_raw;
    logic [SIZE_W-1:0] size_len;
    logic [SIZE_W-1:0] new_fill;
    logic              ring_full;
    logic              last_ring;
    logic              emit_end;

    // Where this pixel lands and whether it closes the ring
    always_comb
    begin
        eff_ring = frame_start ? '0 : ring_reg;
        if ({1'b0, eff_ring} >= RINGS_USED_V)
        begin
            eff_ring = '0;
        end
        eff_fill = frame_start ? '0 : fill_reg;
        size_raw = ring_size[eff_ring];
        if (size_raw == '0)
        begin
            size_len = ONE_SIZE;
        end
        else if (size_raw > MAX_SIZE)
        begin
            size_len = MAX_SIZE;
        end
        else
        begin
            size_len = size_raw;
        end
        new_fill  = SIZE_W'(eff_fill) + ONE_SIZE;
        ring_full = (new_fill >= size_len);
        last_ring = (({1'b0, eff_ring} + (RING_W+1)'(1)) >= RINGS_USED_V);
        emit_end  = (rd_cnt_reg == emit_size_reg + ONE_SIZE);
    end

    assign accept = in_valid && in_ready;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rgbp_pkg::ST_FILL:
            begin
                if (accept && ring_full)
                begin
                    state_next = rgbp_pkg::ST_EMIT;
                end
            end
            rgbp_pkg::ST_EMIT:
            begin
                if (adv && emit_end)
                begin
                    state_next = rgbp_pkg::ST_FILL;
                end
            end
            default:
            begin
                state_next = rgbp_pkg::ST_FILL;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        in_ready          = 1'b0;
        cmd.wr_en         = 1'b0;
        cmd.rd_en         = 1'b0;
        cmd.tag.emit      = (rd_cnt_reg >= TWO_SIZE);
        cmd.tag.ring      = emit_ring_reg;
        cmd.tag.pos       = rgbp_pkg::POS_W'(rd_cnt_reg - TWO_SIZE);
        cmd.tag.ring_done = emit_end;
        cmd.tag.frame_done = emit_end && emit_last_reg;
        unique case (state_reg)
            rgbp_pkg::ST_FILL:
            begin
                in_ready  = 1'b1;
                cmd.wr_en = in_valid;
            end
            rgbp_pkg::ST_EMIT:
            begin
                cmd.rd_en = adv;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    assign wr_addr = eff_fill;
    assign rd_addr = rd_addr_reg;

    // Counters
    always_comb
    begin
        ring_next      = ring_reg;
        fill_next      = fill_reg;
        emit_size_next = emit_size_reg;
        emit_ring_next = emit_ring_reg;
        emit_last_next = emit_last_reg;
        rd_cnt_next    = rd_cnt_reg;
        rd_addr_next   = rd_addr_reg;
        if (accept)
        begin
            if (ring_full)
            begin
                fill_next      = '0;
                ring_next      = last_ring ? '0 : eff_ring + RING_W'(1);
                emit_size_next = size_len;
                emit_ring_next = eff_ring;
                emit_last_next = last_ring;
                rd_cnt_next    = '0;
                // Start one before position zero: its left neighbor wraps
                rd_addr_next   = IDX_W'(size_len - ONE_SIZE);
            end
            else
            begin
                fill_next = IDX_W'(new_fill);
                ring_next = eff_ring;
            end
        end
        else if (cmd.rd_en)
        begin
            rd_cnt_next  = rd_cnt_reg + ONE_SIZE;
            rd_addr_next = (rd_addr_reg == IDX_W'(emit_size_reg - ONE_SIZE)) ?
                           '0 : rd_addr_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rgbp_pkg::ST_FILL;
            ring_reg      <= '0;
            fill_reg      <= '0;
            emit_size_reg <= ONE_SIZE;
            emit_ring_reg <= '0;
            emit_last_reg <= 1'b0;
            rd_cnt_reg    <= '0;
            rd_addr_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            ring_reg      <= ring_next;
            fill_reg      <= fill_next;
            emit_size_reg <= emit_size_next;
            emit_ring_reg <= emit_ring_next;
            emit_last_reg <= emit_last_next;
            rd_cnt_reg    <= rd_cnt_next;
            rd_addr_reg   <= rd_addr_next;
        end
    end

    a_rd_addr_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rgbp_pkg::ST_EMIT) |-> (SIZE_W'(rd_addr_reg) < emit_size_reg))
        else $error("read address beyond ring size");

    a_rd_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rgbp_pkg::ST_EMIT) |-> (rd_cnt_reg <= emit_size_reg + ONE_SIZE))
        else $error("emit pass overran its read count");

    a_ring_close: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && ring_full) |=> (fill_reg == '0 && state_reg == rgbp_pkg::ST_EMIT
                                   && rd_cnt_reg == '0))
        else $error("closed ring did not restart fill and start emit");

endmodule

// ----- design/rgbp_datapath.sv -----
module rgbp_datapath #(
    parameter int MAX_RING_LEDS = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [rgbp_pkg::WGT_W-1:0]          self_weight,
    input  logic [rgbp_pkg::WGT_W-1:0]          neighbour_weight,
    input  rgbp_pkg::cmd_t                      cmd,
    input  logic [$clog2(MAX_RING_LEDS)-1:0]    wr_addr,
    input  logic [$clog2(MAX_RING_LEDS)-1:0]    rd_addr,
    input  rgbp_pkg::pix_t                      wr_pix,
    input  logic                                out_ready,
    output logic                                out_valid,
    output rgbp_pkg::res_t                      out_res,
    output logic                                adv
);

    localparam int NUM_CH = rgbp_pkg::NUM_CH;
    localparam int CH_W   = rgbp_pkg::CH_W;
    localparam int PS_W   = rgbp_pkg::PS_W;
    localparam int PN_W   = rgbp_pkg::PN_W;
    localparam int SUM_W  = rgbp_pkg::SUM_W;
    localparam int RND_W  = rgbp_pkg::RND_W;
    localparam int SCL_W  = rgbp_pkg::SCL_W;
    localparam int FRAC_W = rgbp_pkg::FRAC_W;

    rgbp_pkg::word_t mem [MAX_RING_LEDS];
    rgbp_pkg::word_t wr_word;
    rgbp_pkg::word_t rd_data_reg;

    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg, s5_valid_reg;
    logic out_valid_reg;
    rgbp_pkg::tag_t s1_tag_reg, s2_tag_reg, s3_tag_reg, s4_tag_reg, s5_tag_reg;

    rgbp_pkg::word_t left_reg, mid_reg, right_reg;

    logic [NUM_CH-1:0][PS_W-1:0]  ps_next, ps_reg;
    logic [NUM_CH-1:0][PN_W-1:0]  pn_next, pn_reg;
    logic [NUM_CH-1:0][SUM_W-1:0] sum;
    logic [NUM_CH-1:0][RND_W-1:0] rnd;
    logic [NUM_CH-1:0][CH_W-1:0]  blur_next, blur_reg;
    logic [2:0][SCL_W-1:0]        scl_next, scl_reg;
    logic [2:0][SCL_W:0]          quo_sum;
    logic [2:0][CH_W-1:0]         quo;
    rgbp_pkg::res_t               out_res_next, out_res_reg;

    assign adv = !out_valid_reg || out_ready;

    assign wr_word[rgbp_pkg::CH_RED]   = wr_pix.pix_red;
    assign wr_word[rgbp_pkg::CH_GREEN] = wr_pix.pix_green;
    assign wr_word[rgbp_pkg::CH_BLUE]  = wr_pix.pix_blue;
    assign wr_word[rgbp_pkg::CH_LEVEL] = wr_pix.pix_level;

    // Ring store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[wr_addr] <= wr_word;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
            s1_tag_reg  <= cmd.tag;
        end
    end

    // Blur and scale arithmetic, one lane per channel
    always_comb
    begin
        for (int k = 0; k < NUM_CH; k++)
        begin
            ps_next[k] = PS_W'(self_weight) * PS_W'(mid_reg[k]);
            pn_next[k] = PN_W'(neighbour_weight) *
                         PN_W'({1'b0, left_reg[k]} + {1'b0, right_reg[k]});
            sum[k] = SUM_W'(ps_reg[k]) + SUM_W'(pn_reg[k]) + SUM_W'(1 << (FRAC_W - 1));
            rnd[k] = sum[k][SUM_W-1:FRAC_W];
            blur_next[k] = (rnd[k] > RND_W'(rgbp_pkg::CH_MAX)) ?
                           rgbp_pkg::CH_MAX : rnd[k][CH_W-1:0];
        end
        for (int k = 0; k < 3; k++)
        begin
            scl_next[k] = SCL_W'(blur_reg[k]) * SCL_W'(blur_reg[rgbp_pkg::CH_LEVEL]);
            // Exact divide by 255 for products up to 255 * 255
            quo_sum[k]  = (SCL_W+1)'(scl_reg[k]) + (SCL_W+1)'(scl_reg[k] >> CH_W)
                          + (SCL_W+1)'(1);
            quo[k]      = quo_sum[k][SCL_W-1:CH_W];
        end
        out_res_next.out_ring     = s5_tag_reg.ring;
        out_res_next.out_position = s5_tag_reg.pos;
        out_res_next.out_red      = quo[rgbp_pkg::CH_RED];
        out_res_next.out_green    = quo[rgbp_pkg::CH_GREEN];
        out_res_next.out_blue     = quo[rgbp_pkg::CH_BLUE];
        out_res_next.ring_done    = s5_tag_reg.ring_done;
        out_res_next.frame_done   = s5_tag_reg.frame_done;
    end

    // Payload stages advance together with the valid bits
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (s1_valid_reg)
            begin
                left_reg  <= mid_reg;
                mid_reg   <= right_reg;
                right_reg <= rd_data_reg;
            end
            s2_tag_reg  <= s1_tag_reg;
            ps_reg      <= ps_next;
            pn_reg      <= pn_next;
            s3_tag_reg  <= s2_tag_reg;
            blur_reg    <= blur_next;
            s4_tag_reg  <= s3_tag_reg;
            scl_reg     <= scl_next;
            s5_tag_reg  <= s4_tag_reg;
            out_res_reg <= out_res_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            s5_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg  <= cmd.rd_en;
            s2_valid_reg  <= s1_valid_reg && s1_tag_reg.emit;
            s3_valid_reg  <= s2_valid_reg;
            s4_valid_reg  <= s3_valid_reg;
            s5_valid_reg  <= s4_valid_reg;
            out_valid_reg <= s5_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

    a_read_only_when_moving: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd_en |-> adv)
        else $error("store read issued while the pipeline is stalled");

    a_no_write_during_read: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr_en |-> !cmd.rd_en)
        else $error("store written during an emit pass");

    a_stall_holds_stages: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> ($stable(s5_valid_reg) && $stable(s4_valid_reg) && $stable(s1_valid_reg)))
        else $error("pipeline stage moved during a stall");

endmodule

// ----- design/ring_glow_brightness_postprocess.sv -----
// Ring glow post-processor. Pixels (red, green, blue, level) arrive in ring
// order, ring 0 first; frame_start on a request restarts at ring 0, position 0
// and drops any partly filled ring. Each pixel is written into the ring store
// as it is taken. When a ring's last pixel is taken, input stops for an emit
// pass that reads the store once per cycle while out_ready does not stall it,
// size + 2 reads for a ring of size N (the two extra reads prime the wrapped
// left and right neighbors), all through the single store read port. Results
// leave a six-stage pipeline (read, window, weight products, round and
// saturate, level products, divide by 255), and the next ring's pixels are
// already accepted while the tail drains. A result that waits on out_ready
// stalls the whole emit pipeline, but not the fill side. Each channel is
// blurred as (self_weight * own + neighbour_weight * (left + right) + 512)
// >> 10, saturated to 255; colours are then multiplied by the blurred level
// and divided by 255, truncated. Ring sizes of zero read as one and sizes
// above MAX_RING_LEDS as MAX_RING_LEDS. RING_COUNT is taken as 1 to 4.
// The user must write configuration only while the block is idle; the block
// itself does not enforce this.
module ring_glow_brightness_postprocess #(
    parameter int MAX_RING_LEDS = 64,
    parameter int RING_COUNT    = 4
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration write port
    input  logic                              cfg_we,
    input  logic [rgbp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rgbp_pkg::CFG_DATA_W-1:0]   cfg_data,
    // pixel requests
    input  logic                              in_valid,
    output logic                              in_ready,
    input  rgbp_pkg::pix_t                    in_pix,
    // result requests
    output logic                              out_valid,
    input  logic                              out_ready,
    output rgbp_pkg::res_t                    out_res
);

    localparam int IDX_W  = $clog2(MAX_RING_LEDS);
    localparam int SIZE_W = rgbp_pkg::SIZE_W;
    localparam int WGT_W  = rgbp_pkg::WGT_W;

    logic [rgbp_pkg::MAX_RINGS-1:0][SIZE_W-1:0] ring_size_reg;
    logic [WGT_W-1:0] self_weight_reg;
    logic [WGT_W-1:0] neighbour_weight_reg;

    rgbp_pkg::cmd_t   cmd;
    logic [IDX_W-1:0] wr_addr;
    logic [IDX_W-1:0] rd_addr;
    logic             adv;

    // Configuration registers; writes to unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ring_size_reg[0]     <= rgbp_pkg::RST_RING0_SIZE;
            ring_size_reg[1]     <= rgbp_pkg::RST_RING1_SIZE;
            ring_size_reg[2]     <= rgbp_pkg::RST_RING2_SIZE;
            ring_size_reg[3]     <= rgbp_pkg::RST_RING3_SIZE;
            self_weight_reg      <= rgbp_pkg::RST_SELF_WGT;
            neighbour_weight_reg <= rgbp_pkg::RST_NEIGH_WGT;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                rgbp_pkg::REG_RING0_SIZE: ring_size_reg[0] <= cfg_data[SIZE_W-1:0];
                rgbp_pkg::REG_RING1_SIZE: ring_size_reg[1] <= cfg_data[SIZE_W-1:0];
                rgbp_pkg::REG_RING2_SIZE: ring_size_reg[2] <= cfg_data[SIZE_W-1:0];
                rgbp_pkg::REG_RING3_SIZE: ring_size_reg[3] <= cfg_data[SIZE_W-1:0];
                rgbp_pkg::REG_SELF_WGT:   self_weight_reg  <= cfg_data[WGT_W-1:0];
                rgbp_pkg::REG_NEIGH_WGT:  neighbour_weight_reg <= cfg_data[WGT_W-1:0];
                default:
                begin
                    // hold: index names no register
                end
            endcase
        end
    end

    // Sequence fill and emit passes, track ring and fill position
    rgbp_ctrl #(
        .MAX_RING_LEDS (MAX_RING_LEDS),
        .RING_COUNT    (RING_COUNT)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .ring_size   (ring_size_reg),
        .in_valid    (in_valid),
        .frame_start (in_pix.frame_start),
        .in_ready    (in_ready),
        .adv         (adv),
        .cmd         (cmd),
        .wr_addr     (wr_addr),
        .rd_addr     (rd_addr)
    );

    // Ring store, neighbor window, blur and scale pipeline, output register
    rgbp_datapath #(
        .MAX_RING_LEDS (MAX_RING_LEDS)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .self_weight      (self_weight_reg),
        .neighbour_weight (neighbour_weight_reg),
        .cmd              (cmd),
        .wr_addr          (wr_addr),
        .rd_addr          (rd_addr),
        .wr_pix           (in_pix),
        .out_ready        (out_ready),
        .out_valid        (out_valid),
        .out_res          (out_res),
        .adv              (adv)
    );

endmodule
